>>> hw/rtl/tfr_pkg.sv
package tfr_pkg;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int PAL_WIDTH     = 16;

    // Pixel format codes
    localparam logic [1:0] FMT_INTENSITY = 2'd0;
    localparam logic [1:0] FMT_INT_ALPHA = 2'd1;
    localparam logic [1:0] FMT_RGBA      = 2'd2;
    localparam logic [1:0] FMT_COLOR_IDX = 2'd3;

    // Pixel size codes
    localparam logic [1:0] SIZE_4B  = 2'd0;
    localparam logic [1:0] SIZE_8B  = 2'd1;
    localparam logic [1:0] SIZE_16B = 2'd2;
    localparam logic [1:0] SIZE_32B = 2'd3;

    // Request kinds
    localparam logic REQ_CONVERT   = 1'b0;
    localparam logic REQ_PAL_WRITE = 1'b1;

    // Register indexes (byte address bit 2)
    localparam logic REG_PIXEL_FORMAT = 1'b0;
    localparam logic REG_PIXEL_SIZE   = 1'b1;

    // Red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic [1:0] pixel_size;
    } cfg_t;

    // Decoded texel passed from the decode stage to the output stage
    typedef struct packed {
        rgba_t color;
        logic  use_pal;
        logic  pal_zero;
        logic  err;
    } dec_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic rgba_t expand5551(input logic [15:0] h);
        rgba_t c;
        c.red   = widen5(h[15:11]);
        c.green = widen5(h[10:6]);
        c.blue  = widen5(h[5:1]);
        c.alpha = {8{h[0]}};
        expand5551 = c;
    endfunction

endpackage

>>> hw/rtl/tfr_ram.sv
module tfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write or registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tfr_decode.sv
module tfr_decode (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tfr_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_req,
    input  logic [31:0]                    in_word,
    input  logic                           in_odd,
    input  logic [7:0]                     in_idx,
    input  logic [15:0]                    in_val,
    output logic                           dec_valid,
    input  logic                           dec_ready,
    output tfr_pkg::dec_t                  dec,
    output logic [tfr_pkg::PAL_WIDTH-1:0]  pal_data
);

    // Stage A: captured input transaction
    logic        a_valid_reg, a_valid_next;
    logic        a_req_reg;
    logic [31:0] a_word_reg;
    logic        a_odd_reg;
    logic [7:0]  a_idx_reg;
    logic [15:0] a_val_reg;

    // Stage B: decoded texel
    logic          b_valid_reg, b_valid_next;
    tfr_pkg::dec_t b_dec_reg, b_dec_next;

    logic b_ready;
    logic a_ready;

    logic [3:0] nib;
    logic [7:0] lo_byte;
    logic [2:0] ia_val;
    logic       ia_alpha;
    logic [7:0] ci;
    logic       ci_ok;
    logic       idx_ok;
    logic       ram_we;
    logic       ram_re;
    logic [tfr_pkg::PAL_AW-1:0] ram_addr;

    // Ready chain: a stage takes new data when empty or draining
    assign b_ready  = !b_valid_reg || dec_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_ready) begin
            a_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // Load stage A payload on acceptance
    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_req_reg  <= in_req;
            a_word_reg <= in_word;
            a_odd_reg  <= in_odd;
            a_idx_reg  <= in_idx;
            a_val_reg  <= in_val;
        end
    end

    // Decode the texel under the configured format and size
    always_comb begin
        nib      = a_odd_reg ? a_word_reg[3:0] : a_word_reg[7:4];
        lo_byte  = a_word_reg[7:0];
        ia_val   = a_odd_reg ? lo_byte[3:1] : lo_byte[7:5];
        ia_alpha = a_odd_reg ? lo_byte[0] : lo_byte[4];
        ci       = (cfg.pixel_size == tfr_pkg::SIZE_4B) ? {4'h0, nib} : lo_byte;
        ci_ok    = int'(ci) < tfr_pkg::PALETTE_DEPTH;

        b_dec_next          = '0;
        case (cfg.pixel_format)
            tfr_pkg::FMT_INTENSITY: begin
                if (cfg.pixel_size == tfr_pkg::SIZE_4B) begin
                    b_dec_next.color = '{alpha: 8'hff, blue: {nib, nib},
                                         green: {nib, nib}, red: {nib, nib}};
                end else if (cfg.pixel_size == tfr_pkg::SIZE_8B) begin
                    b_dec_next.color = '{alpha: 8'hff, blue: lo_byte,
                                         green: lo_byte, red: lo_byte};
                end else begin
                    b_dec_next.err = 1'b1;
                end
            end
            tfr_pkg::FMT_INT_ALPHA: begin
                if (cfg.pixel_size == tfr_pkg::SIZE_4B) begin
                    b_dec_next.color.red   = {ia_val, ia_val, ia_val[2:1]};
                    b_dec_next.color.green = {ia_val, ia_val, ia_val[2:1]};
                    b_dec_next.color.blue  = {ia_val, ia_val, ia_val[2:1]};
                    b_dec_next.color.alpha = {8{ia_alpha}};
                end else if (cfg.pixel_size == tfr_pkg::SIZE_8B) begin
                    b_dec_next.color.red   = {lo_byte[7:4], lo_byte[7:4]};
                    b_dec_next.color.green = {lo_byte[7:4], lo_byte[7:4]};
                    b_dec_next.color.blue  = {lo_byte[7:4], lo_byte[7:4]};
                    b_dec_next.color.alpha = {lo_byte[3:0], lo_byte[3:0]};
                end else begin
                    b_dec_next.err = 1'b1;
                end
            end
            tfr_pkg::FMT_RGBA: begin
                if (cfg.pixel_size == tfr_pkg::SIZE_16B) begin
                    b_dec_next.color = tfr_pkg::expand5551(a_word_reg[15:0]);
                end else if (cfg.pixel_size == tfr_pkg::SIZE_32B) begin
                    b_dec_next.color = '{alpha: a_word_reg[7:0], blue: a_word_reg[15:8],
                                         green: a_word_reg[23:16],
                                         red: a_word_reg[31:24]};
                end else begin
                    b_dec_next.err = 1'b1;
                end
            end
            tfr_pkg::FMT_COLOR_IDX: begin
                if (cfg.pixel_size == tfr_pkg::SIZE_4B ||
                    cfg.pixel_size == tfr_pkg::SIZE_8B) begin
                    b_dec_next.use_pal  = 1'b1;
                    b_dec_next.pal_zero = !ci_ok;
                end else begin
                    b_dec_next.err = 1'b1;
                end
            end
            default: begin
                b_dec_next.err = 1'b1;
            end
        endcase

        // Only convert transactions produce a result
        b_valid_next = b_valid_reg;
        if (b_ready) begin
            b_valid_next = a_valid_reg && (a_req_reg == tfr_pkg::REQ_CONVERT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready) begin
            b_dec_reg <= b_dec_next;
        end
    end

    // Palette access: writes and lookups both happen as stage A moves on
    assign idx_ok   = int'(a_idx_reg) < tfr_pkg::PALETTE_DEPTH;
    assign ram_we   = b_ready && a_valid_reg && (a_req_reg == tfr_pkg::REQ_PAL_WRITE) && idx_ok;
    assign ram_re   = b_ready && a_valid_reg && (a_req_reg == tfr_pkg::REQ_CONVERT) &&
                      b_dec_next.use_pal && !b_dec_next.pal_zero;
    assign ram_addr = (a_req_reg == tfr_pkg::REQ_PAL_WRITE) ?
                      a_idx_reg[tfr_pkg::PAL_AW-1:0] : ci[tfr_pkg::PAL_AW-1:0];

    tfr_ram #(
        .WIDTH (tfr_pkg::PAL_WIDTH),
        .DEPTH (tfr_pkg::PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (a_val_reg),
        .rdata (pal_data)
    );

    assign dec_valid = b_valid_reg;
    assign dec       = b_dec_reg;

    // A stalled decoded texel stays in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !dec_ready |=> b_valid_reg)
        else $error("decode stage dropped a stalled texel");

    // A palette write never turns into a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && b_ready && (a_req_reg == tfr_pkg::REQ_PAL_WRITE) |=> !b_valid_reg)
        else $error("palette write produced a result");

    // The palette port never writes and reads in one cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("palette port has a write and a read at once");

endmodule

>>> hw/rtl/tfr_expand.sv
module tfr_expand (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           dec_valid,
    output logic                           dec_ready,
    input  tfr_pkg::dec_t                  dec,
    input  logic [tfr_pkg::PAL_WIDTH-1:0]  pal_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tfr_pkg::rgba_t                 out_color,
    output logic                           out_err
);

    logic           c_valid_reg, c_valid_next;
    tfr_pkg::rgba_t c_color_reg, c_color_next;
    logic           c_err_reg;
    logic           c_ready;

    assign c_ready   = !c_valid_reg || out_ready;
    assign dec_ready = c_ready;

    // Pick the palette color or the direct color
    always_comb begin
        c_color_next = dec.color;
        if (dec.use_pal) begin
            c_color_next = dec.pal_zero ? '0 : tfr_pkg::expand5551(pal_data);
        end
        c_valid_next = c_valid_reg;
        if (c_ready) begin
            c_valid_next = dec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (c_ready && dec_valid) begin
            c_color_reg <= c_color_next;
            c_err_reg   <= dec.err;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_color = c_color_reg;
    assign out_err   = c_err_reg;

    // An unsupported pair always gives a black transparent texel
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && c_err_reg |-> c_color_reg == '0)
        else $error("format error with nonzero color");

endmodule

>>> hw/rtl/texel_format_to_rgba8888_core.sv
// Texel format converter: raw texel in, 8-bit RGBA out.
//
// Input channel s_*: one transaction per texel to convert (s_tuser low) or
// per palette entry to store (s_tuser high). Palette writes give no result.
// Output channel m_*: one transaction per converted texel, red in the low
// byte, format_error on m_tuser.
// Configuration: APB port, pixel_format at 0x0, pixel_size at 0x4; write
// only while no texel is in flight.
//
// Throughput is one transaction per cycle in both directions while m_tready
// stays high. The input, decode and output registers each add one stage;
// an accepted texel passes them in that order before m_tvalid rises. The
// palette lookup sits in the decode step on a single-port RAM with
// registered read.
// When m_tready is low the output register holds, upstream stages fill
// their empty slots, and s_tready drops once all three stages are full.
// Reset clears all valid bits and both registers to zero; palette contents
// are undefined until written, and no clearing pass is made.
module texel_format_to_rgba8888_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // texel_word[31:0], odd_texel[32], palette_index[40:33],
                                  // palette_value[56:41], zero[63:57]
    input  logic        s_tuser,  // req_type[0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        m_tuser   // format_error[0]
);

    logic [1:0]     pixel_format_reg, pixel_format_next;
    logic [1:0]     pixel_size_reg, pixel_size_next;
    tfr_pkg::cfg_t  cfg;
    logic           cfg_write;

    logic           dec_valid;
    logic           dec_ready;
    tfr_pkg::dec_t  dec;
    logic [tfr_pkg::PAL_WIDTH-1:0] pal_data;
    tfr_pkg::rgba_t out_color;

    // Register write decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        pixel_format_next = pixel_format_reg;
        pixel_size_next   = pixel_size_reg;
        if (cfg_write) begin
            case (paddr[2])
                tfr_pkg::REG_PIXEL_FORMAT: pixel_format_next = pwdata[1:0];
                tfr_pkg::REG_PIXEL_SIZE:   pixel_size_next   = pwdata[1:0];
                default: begin
                    pixel_format_next = pixel_format_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= tfr_pkg::FMT_INTENSITY;
            pixel_size_reg   <= tfr_pkg::SIZE_4B;
        end else begin
            pixel_format_reg <= pixel_format_next;
            pixel_size_reg   <= pixel_size_next;
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            tfr_pkg::REG_PIXEL_FORMAT: prdata = {30'd0, pixel_format_reg};
            tfr_pkg::REG_PIXEL_SIZE:   prdata = {30'd0, pixel_size_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.pixel_format = pixel_format_reg;
    assign cfg.pixel_size   = pixel_size_reg;

    tfr_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_word   (s_tdata[31:0]),
        .in_odd    (s_tdata[32]),
        .in_idx    (s_tdata[40:33]),
        .in_val    (s_tdata[56:41]),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .pal_data  (pal_data)
    );

    tfr_expand u_expand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .pal_data  (pal_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_color (out_color),
        .out_err   (m_tuser)
    );

    assign m_tdata = out_color;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_ITEMS   = 40;

    // Expected converted pixel: color plus error flag
    typedef struct packed {
        logic           err;
        tfr_pkg::rgba_t color;
    } pixel_result_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;  // texel_word, odd_texel, palette_index, palette_value, zero pad
    logic        s_tuser;  // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;  // red, green, blue, alpha
    logic        m_tuser;  // format_error

    // Shadow of the block's configuration and palette
    logic [1:0]  cur_format;
    logic [1:0]  cur_size;
    logic [15:0] palette_copy [tfr_pkg::PALETTE_DEPTH];
    bit          palette_written [tfr_pkg::PALETTE_DEPTH];

    pixel_result_t expected_pixels[$];
    int          error_count;
    int          cycle_count;
    bit          burst_mode;

    texel_format_to_rgba8888_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Widen a 5:5:5:1 word to 8 bits per channel
    function automatic tfr_pkg::rgba_t unpack_5551(input logic [15:0] h);
        return {{8{h[0]}}, {h[5:1], h[5:3]}, {h[10:6], h[10:8]}, {h[15:11], h[15:13]}};
    endfunction

    // Decode one texel under the current format and size
    function automatic pixel_result_t predict_pixel(input logic [31:0] word, input logic odd);
        pixel_result_t res;
        logic [3:0]    nib;
        logic [2:0]    level;
        logic          flag;
        logic [7:0]    gray;
        logic [7:0]    idx;
        res  = '0;
        nib  = odd ? word[3:0] : word[7:4];
        case (cur_format)
            tfr_pkg::FMT_INTENSITY: begin
                if (cur_size == tfr_pkg::SIZE_4B || cur_size == tfr_pkg::SIZE_8B) begin
                    gray = (cur_size == tfr_pkg::SIZE_4B) ? {nib, nib} : word[7:0];
                    res.color = {8'hff, gray, gray, gray};
                end else begin
                    res.err = 1'b1;
                end
            end
            tfr_pkg::FMT_INT_ALPHA: begin
                if (cur_size == tfr_pkg::SIZE_4B) begin
                    level = odd ? word[3:1] : word[7:5];
                    flag  = odd ? word[0] : word[4];
                    gray  = {level, level, level[2:1]};
                    res.color = {{8{flag}}, gray, gray, gray};
                end else if (cur_size == tfr_pkg::SIZE_8B) begin
                    gray = {word[7:4], word[7:4]};
                    res.color = {word[3:0], word[3:0], gray, gray, gray};
                end else begin
                    res.err = 1'b1;
                end
            end
            tfr_pkg::FMT_RGBA: begin
                if (cur_size == tfr_pkg::SIZE_16B) begin
                    res.color = unpack_5551(word[15:0]);
                end else if (cur_size == tfr_pkg::SIZE_32B) begin
                    res.color = {word[7:0], word[15:8], word[23:16], word[31:24]};
                end else begin
                    res.err = 1'b1;
                end
            end
            tfr_pkg::FMT_COLOR_IDX: begin
                if (cur_size == tfr_pkg::SIZE_4B || cur_size == tfr_pkg::SIZE_8B) begin
                    idx = (cur_size == tfr_pkg::SIZE_4B) ? {4'h0, nib} : word[7:0];
                    res.color = unpack_5551(palette_copy[idx]);
                end else begin
                    res.err = 1'b1;
                end
            end
            default: res.err = 1'b1;
        endcase
        return res;
    endfunction

    // Send one request transaction after a random gap (none in burst mode) and record its effect
    task automatic send_request(input logic req, input logic [31:0] word, input logic odd,
                                input logic [7:0] pidx, input logic [15:0] pval);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'd0, pval, pidx, odd, word};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (req == tfr_pkg::REQ_PAL_WRITE) begin
            palette_copy[pidx]    = pval;
            palette_written[pidx] = 1'b1;
        end else begin
            expected_pixels.push_back(predict_pixel(word, odd));
        end
    endtask

    task automatic convert(input logic [31:0] word, input logic odd);
        send_request(tfr_pkg::REQ_CONVERT, word, odd, 8'($urandom), 16'($urandom));
    endtask

    task automatic write_palette(input logic [7:0] pidx, input logic [15:0] pval);
        send_request(tfr_pkg::REQ_PAL_WRITE, $urandom, 1'($urandom), pidx, pval);
    endtask

    // Hold the input idle until every result is back, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {30'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == tfr_pkg::REG_PIXEL_FORMAT) cur_format = value;
        else cur_size = value;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] fmt, input logic [1:0] size);
        wait_idle();
        apb_write(tfr_pkg::REG_PIXEL_FORMAT, fmt);
        apb_write(tfr_pkg::REG_PIXEL_SIZE, size);
    endtask

    task automatic test_intensity();
        set_config(tfr_pkg::FMT_INTENSITY, tfr_pkg::SIZE_4B);
        convert(32'h0000_00f0, 1'b0);
        convert(32'hffff_fff0, 1'b1);
        set_config(tfr_pkg::FMT_INTENSITY, tfr_pkg::SIZE_8B);
        convert(32'hffff_ff00, 1'b1);
        convert(32'h0000_00ff, 1'b0);
    endtask

    task automatic test_intensity_alpha();
        set_config(tfr_pkg::FMT_INT_ALPHA, tfr_pkg::SIZE_4B);
        convert(32'h0000_00f0, 1'b0);
        convert(32'h0000_001f, 1'b1);
        set_config(tfr_pkg::FMT_INT_ALPHA, tfr_pkg::SIZE_8B);
        convert(32'h0000_00a5, 1'b0);
        convert(32'hffff_ff0f, 1'b0);
    endtask

    task automatic test_rgba();
        set_config(tfr_pkg::FMT_RGBA, tfr_pkg::SIZE_16B);
        convert(32'h0000_ffff, 1'b0);
        convert(32'hffff_f801, 1'b1);
        set_config(tfr_pkg::FMT_RGBA, tfr_pkg::SIZE_32B);
        convert(32'h1234_5678, 1'b0);
        convert(32'hffff_ffff, 1'b1);
    endtask

    task automatic test_color_index();
        set_config(tfr_pkg::FMT_COLOR_IDX, tfr_pkg::SIZE_4B);
        write_palette(8'd0, 16'hffff);
        write_palette(8'd15, 16'h07c0);
        write_palette(8'd255, 16'h003f);
        convert(32'h0000_000f, 1'b0);
        convert(32'h0000_000f, 1'b1);
        set_config(tfr_pkg::FMT_COLOR_IDX, tfr_pkg::SIZE_8B);
        convert(32'h0000_00ff, 1'b0);
        convert(32'hffff_ff0f, 1'b1);
    endtask

    task automatic test_unsupported_pairs();
        set_config(tfr_pkg::FMT_INTENSITY, tfr_pkg::SIZE_16B);
        convert(32'hffff_ffff, 1'b1);
        set_config(tfr_pkg::FMT_INT_ALPHA, tfr_pkg::SIZE_32B);
        convert(32'hffff_ffff, 1'b0);
        set_config(tfr_pkg::FMT_RGBA, tfr_pkg::SIZE_4B);
        convert(32'hffff_ffff, 1'b1);
        set_config(tfr_pkg::FMT_COLOR_IDX, tfr_pkg::SIZE_16B);
        convert(32'hffff_ffff, 1'b0);
    endtask

    // Mix of palette writes and conversions; palette entries are written before use
    task automatic send_random_item();
        logic [31:0] word;
        logic        odd;
        logic [7:0]  idx;
        word = $urandom;
        odd  = 1'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            write_palette(8'($urandom), 16'($urandom));
        end else begin
            if (cur_format == tfr_pkg::FMT_COLOR_IDX &&
                (cur_size == tfr_pkg::SIZE_4B || cur_size == tfr_pkg::SIZE_8B)) begin
                idx = (cur_size == tfr_pkg::SIZE_4B) ?
                      {4'h0, (odd ? word[3:0] : word[7:4])} : word[7:0];
                if (!palette_written[idx]) write_palette(idx, 16'($urandom));
            end
            convert(word, odd);
        end
    endtask

    task automatic test_random();
        logic [1:0] fmt;
        logic [1:0] size;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Walk every format and size pair, then pick at random
            fmt  = (phase < 16) ? 2'(phase >> 2) : 2'($urandom);
            size = (phase < 16) ? 2'(phase) : 2'($urandom);
            set_config(fmt, size);
            burst_mode = (phase % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off the sender once until the pipeline is empty
                if (phase == 10 && n == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (expected_pixels.size() != 0) @(posedge aclk);
                    @(posedge aclk);
                end
                send_random_item();
            end
            burst_mode = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Check each result transaction against the oldest expectation
    always @(posedge aclk) begin : check_results
        pixel_result_t exp_pix;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("result with no expectation: tdata %0h tuser %0b", m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_pix = expected_pixels.pop_front();
                compare_field("red", exp_pix.color.red, m_tdata[7:0]);
                compare_field("green", exp_pix.color.green, m_tdata[15:8]);
                compare_field("blue", exp_pix.color.blue, m_tdata[23:16]);
                compare_field("alpha", exp_pix.color.alpha, m_tdata[31:24]);
                compare_field("format_error", {7'd0, exp_pix.err}, {7'd0, m_tuser});
            end
        end
    end

    // Stall the result side for a random number of cycles per transaction, except in burst mode
    initial begin : result_ready
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        burst_mode  = 1'b0;
        cur_format  = tfr_pkg::FMT_INTENSITY;
        cur_size    = tfr_pkg::SIZE_4B;
        for (int i = 0; i < tfr_pkg::PALETTE_DEPTH; i++) begin
            palette_copy[i]    = '0;
            palette_written[i] = 1'b0;
        end
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= tfr_pkg::REQ_CONVERT;
        m_tready <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_intensity();
        test_intensity_alpha();
        test_rgba();
        test_color_index();
        test_unsupported_pairs();
        test_random();

        // Drain, then watch for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_ram.sv
hw/rtl/tfr_decode.sv
hw/rtl/tfr_expand.sv
hw/rtl/texel_format_to_rgba8888_core.sv
test/testbench.sv
